@@ hdl/alds_pkg.sv @@
// ----------------------------------------------------------------------------
// alds_pkg
// Shared widths, codes and defaults of the access log distinct range counter.
// ----------------------------------------------------------------------------
package alds_pkg;

    localparam int ID_W  = 17;
    localparam int POS_W = 16;
    localparam int CNT_W = 17;

    localparam int LOG_DEPTH_DEFAULT = 65536;
    localparam int ID_SPACE_DEFAULT  = 131072;

    localparam logic [ID_W-1:0]  ID_LIMIT_RESET = 17'd99999;
    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

endpackage

@@ hdl/alds_ram.sv @@
// ----------------------------------------------------------------------------
// alds_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. A read in the same cycle as a write to that entry returns old data.
// ----------------------------------------------------------------------------
module alds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/access_log_distinct_range_counter_unit.sv @@
// ----------------------------------------------------------------------------
// access_log_distinct_range_counter_unit
// Append-only visitor id log with per-id visit counters and range queries
// that count the distinct ids between two log positions.
// ----------------------------------------------------------------------------
// Append: the state RAM is read at acceptance, then S_APPEND writes it back
// and raises done; a reject raises done straight from the idle state. A query
// raises done after two walks over the log RAM (mark, then unmark), one entry a cycle.
// One transaction at a time; busy is high until the result is issued.
// After reset the id state RAM is cleared entry by entry, with busy high.
// The receiver cannot stall: each result is valid for the single done cycle.
module access_log_distinct_range_counter_unit #(
    parameter int LOG_DEPTH = alds_pkg::LOG_DEPTH_DEFAULT,
    parameter int ID_SPACE  = alds_pkg::ID_SPACE_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [alds_pkg::ID_W-1:0]  id,
    input  logic [alds_pkg::POS_W-1:0] range_start,
    input  logic [alds_pkg::POS_W-1:0] range_end,
    output logic                       done,
    output logic                       status,
    output logic [alds_pkg::CNT_W-1:0] visit_count,
    output logic [alds_pkg::CNT_W-1:0] distinct_count,
    output logic [alds_pkg::CNT_W-1:0] total_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [alds_pkg::ID_W-1:0]  cfg_data
);

    localparam int LOG_AW = $clog2(LOG_DEPTH);
    localparam int ID_AW  = $clog2(ID_SPACE);
    localparam int FILL_W = LOG_AW + 1;
    localparam int ST_W   = alds_pkg::CNT_W + 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_MARK   = 3'd3;
    localparam logic [2:0] S_UNMARK = 3'd4;

    localparam logic [ID_AW-1:0] CLR_LAST = ID_AW'(ID_SPACE - 1);

    logic [2:0]                 state_reg, state_next;
    logic [ID_AW-1:0]           clr_addr_reg, clr_addr_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [alds_pkg::ID_W-1:0]  id_limit_reg, id_limit_next;
    logic                       issue_on_reg, issue_on_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s2_valid_reg, s2_valid_next;
    logic                       fw_valid_reg, fw_valid_next;
    logic                       done_reg, done_next;

    logic [alds_pkg::ID_W-1:0]  id_reg, id_next;
    logic [alds_pkg::POS_W-1:0] lo_reg, lo_next;
    logic [alds_pkg::POS_W-1:0] hi_reg, hi_next;
    logic [alds_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [alds_pkg::CNT_W-1:0] distinct_reg, distinct_next;
    logic [ID_AW-1:0]           s2_id_reg, s2_id_next;
    logic [ID_AW-1:0]           fw_addr_reg, fw_addr_next;
    logic [ST_W-1:0]            fw_data_reg, fw_data_next;
    logic                       status_reg, status_next;
    logic [alds_pkg::CNT_W-1:0] visit_reg, visit_next;
    logic [alds_pkg::CNT_W-1:0] distinct_out_reg, distinct_out_next;
    logic [alds_pkg::CNT_W-1:0] total_reg, total_next;

    logic                       log_we;
    logic [LOG_AW-1:0]          log_waddr;
    logic [alds_pkg::ID_W-1:0]  log_wdata;
    logic                       log_re;
    logic [LOG_AW-1:0]          log_raddr;
    logic [alds_pkg::ID_W-1:0]  log_rdata;

    logic                       st_we;
    logic [ID_AW-1:0]           st_waddr;
    logic [ST_W-1:0]            st_wdata;
    logic                       st_re;
    logic [ID_AW-1:0]           st_raddr;
    logic [ST_W-1:0]            st_rdata;

    logic [ST_W-1:0]            s2_cur;
    logic [ST_W-1:0]            s2_word;
    logic [alds_pkg::CNT_W-1:0] app_cnt;
    logic [alds_pkg::CNT_W-1:0] app_cnt_inc;
    logic                       append_ok;
    logic                       query_ok;
    logic                       accept;

    alds_ram #(
        .WIDTH (alds_pkg::ID_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_wdata),
        .re    (log_re),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    // Each word holds the visit counter above the seen mark.
    alds_ram #(
        .WIDTH (ST_W),
        .DEPTH (ID_SPACE)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign append_ok = (id <= id_limit_reg) && (32'(id) < ID_SPACE)
                       && (32'(fill_reg) < LOG_DEPTH);
    assign query_ok  = (range_start <= range_end) && (32'(range_end) < 32'(fill_reg))
                       && (32'(range_end) < LOG_DEPTH);

    // A write issued in the cycle of a read is not seen by that read.
    assign s2_cur  = (fw_valid_reg && (fw_addr_reg == s2_id_reg)) ? fw_data_reg : st_rdata;
    assign s2_word = {s2_cur[ST_W-1:1], (state_reg == S_MARK)};

    assign app_cnt     = st_rdata[ST_W-1:1];
    assign app_cnt_inc = (app_cnt == alds_pkg::CNT_MAX) ? app_cnt
                                                        : app_cnt + alds_pkg::CNT_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        fill_next         = fill_reg;
        id_limit_next     = id_limit_reg;
        issue_on_next     = issue_on_reg;
        s1_valid_next     = 1'b0;
        s2_valid_next     = s1_valid_reg;
        fw_valid_next     = s2_valid_reg;
        done_next         = 1'b0;
        id_next           = id_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        pos_next          = pos_reg;
        distinct_next     = distinct_reg;
        s2_id_next        = ID_AW'(log_rdata);
        fw_addr_next      = s2_id_reg;
        fw_data_next      = s2_word;
        status_next       = status_reg;
        visit_next        = visit_reg;
        distinct_out_next = distinct_out_reg;
        total_next        = total_reg;

        log_we    = 1'b0;
        log_waddr = fill_reg[LOG_AW-1:0];
        log_wdata = id_reg;
        log_re    = 1'b0;
        log_raddr = LOG_AW'(pos_reg);

        st_we    = s2_valid_reg;
        st_waddr = s2_id_reg;
        st_wdata = s2_word;
        st_re    = s1_valid_reg;
        st_raddr = ID_AW'(log_rdata);

        if (cfg_valid)
        begin
            id_limit_next = cfg_data;
        end

        if (s2_valid_reg && (state_reg == S_MARK) && !s2_cur[0])
        begin
            distinct_next = distinct_reg + alds_pkg::CNT_W'(1);
        end

        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_addr_reg;
                st_wdata = '0;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ID_AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((kind == alds_pkg::KIND_QUERY) ? query_ok : append_ok)
                    begin
                        if (kind == alds_pkg::KIND_QUERY)
                        begin
                            lo_next       = range_start;
                            hi_next       = range_end;
                            pos_next      = range_start;
                            issue_on_next = 1'b1;
                            distinct_next = '0;
                            state_next    = S_MARK;
                        end
                        else
                        begin
                            id_next    = id;
                            st_re      = 1'b1;
                            st_raddr   = ID_AW'(id);
                            state_next = S_APPEND;
                        end
                    end
                    else
                    begin
                        done_next         = 1'b1;
                        status_next       = alds_pkg::STATUS_REJECT;
                        visit_next        = '0;
                        distinct_out_next = '0;
                        total_next        = '0;
                    end
                end
            end
            S_APPEND:
            begin
                st_we             = 1'b1;
                st_waddr          = ID_AW'(id_reg);
                st_wdata          = {app_cnt_inc, st_rdata[0]};
                log_we            = 1'b1;
                fill_next         = fill_reg + FILL_W'(1);
                done_next         = 1'b1;
                status_next       = alds_pkg::STATUS_OK;
                visit_next        = app_cnt_inc;
                distinct_out_next = '0;
                total_next        = '0;
                state_next        = S_IDLE;
            end
            S_MARK, S_UNMARK:
            begin
                if (issue_on_reg)
                begin
                    log_re        = 1'b1;
                    s1_valid_next = 1'b1;
                    if (pos_reg == hi_reg)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + alds_pkg::POS_W'(1);
                    end
                end
                else if (!s1_valid_reg && !s2_valid_reg)
                begin
                    if (state_reg == S_MARK)
                    begin
                        pos_next      = lo_reg;
                        issue_on_next = 1'b1;
                        state_next    = S_UNMARK;
                    end
                    else
                    begin
                        done_next         = 1'b1;
                        status_next       = alds_pkg::STATUS_OK;
                        visit_next        = '0;
                        distinct_out_next = distinct_reg;
                        total_next        = {1'b0, hi_reg} - {1'b0, lo_reg}
                                            + alds_pkg::CNT_W'(1);
                        state_next        = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            fill_reg     <= '0;
            id_limit_reg <= alds_pkg::ID_LIMIT_RESET;
            issue_on_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            fill_reg     <= fill_next;
            id_limit_reg <= id_limit_next;
            issue_on_reg <= issue_on_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            fw_valid_reg <= fw_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg           <= id_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        pos_reg          <= pos_next;
        distinct_reg     <= distinct_next;
        s2_id_reg        <= s2_id_next;
        fw_addr_reg      <= fw_addr_next;
        fw_data_reg      <= fw_data_next;
        status_reg       <= status_next;
        visit_reg        <= visit_next;
        distinct_out_reg <= distinct_out_next;
        total_reg        <= total_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign status         = status_reg;
    assign visit_count    = visit_reg;
    assign distinct_count = distinct_out_reg;
    assign total_count    = total_reg;

    a_walk_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == S_MARK || state_reg == S_UNMARK))
        else $error("Log walk pipeline active outside a query pass.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= LOG_DEPTH)
        else $error("Log fill count exceeds the log depth.");

    a_distinct_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == alds_pkg::STATUS_OK)) |-> (distinct_out_reg <= total_reg))
        else $error("Distinct count exceeds the span length.");

    a_append_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND) |=> (done_reg && (state_reg == S_IDLE)))
        else $error("Append did not complete in one step.");

endmodule

@@ tb/sv/tb_access_log_distinct_range_counter_unit.sv @@
// ----------------------------------------------------------------------------
// tb_access_log_distinct_range_counter_unit
// Self-checking bench for the visitor log: a short directed table of appends
// and range queries, random phases under several id limits and idle rates,
// then a query over the whole log. Every result is checked against the table or a local model.
// ----------------------------------------------------------------------------
module tb_access_log_distinct_range_counter_unit;

    localparam int LOG_DEPTH   = alds_pkg::LOG_DEPTH_DEFAULT;
    localparam int ID_SPACE    = alds_pkg::ID_SPACE_DEFAULT;
    localparam int SCRIPT_ROWS = 21;
    localparam int STALL_LIMIT = 600000;

    typedef struct packed {
        logic                       status;
        logic [alds_pkg::CNT_W-1:0] visit;
        logic [alds_pkg::CNT_W-1:0] distinct;
        logic [alds_pkg::CNT_W-1:0] total;
    } log_reply_t;

    typedef struct packed {
        logic                       set_limit;
        logic [alds_pkg::ID_W-1:0]  limit;
        logic                       kind;
        logic [alds_pkg::ID_W-1:0]  who;
        logic [alds_pkg::POS_W-1:0] lo;
        logic [alds_pkg::POS_W-1:0] hi;
        logic                       typed;
        log_reply_t                 reply;
    } script_row_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       start       = 1'b0;
    logic                       kind        = alds_pkg::KIND_APPEND;
    logic [alds_pkg::ID_W-1:0]  id          = '0;
    logic [alds_pkg::POS_W-1:0] range_start = '0;
    logic [alds_pkg::POS_W-1:0] range_end   = '0;
    logic                       cfg_valid   = 1'b0;
    logic [alds_pkg::ID_W-1:0]  cfg_data    = '0;
    logic                       busy;
    logic                       done;
    logic                       status;
    logic [alds_pkg::CNT_W-1:0] visit_count;
    logic [alds_pkg::CNT_W-1:0] distinct_count;
    logic [alds_pkg::CNT_W-1:0] total_count;
    logic                       cfg_ready;

    bit   [alds_pkg::ID_W-1:0]  log_ids     [LOG_DEPTH];
    bit   [alds_pkg::CNT_W-1:0] visit_tally [ID_SPACE];
    bit                         seen_ids    [ID_SPACE];
    int                         log_fill    = 0;
    logic [alds_pkg::ID_W-1:0]  model_limit = alds_pkg::ID_LIMIT_RESET;

    log_reply_t       pending_replies [$];
    log_reply_t       check_want;
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;

    access_log_distinct_range_counter_unit #(
        .LOG_DEPTH (LOG_DEPTH),
        .ID_SPACE  (ID_SPACE)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .id             (id),
        .range_start    (range_start),
        .range_end      (range_end),
        .done           (done),
        .status         (status),
        .visit_count    (visit_count),
        .distinct_count (distinct_count),
        .total_count    (total_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic log_reply_t predict_reply(input logic k,
                                                 input logic [alds_pkg::ID_W-1:0] who,
                                                 input logic [alds_pkg::POS_W-1:0] lo,
                                                 input logic [alds_pkg::POS_W-1:0] hi);
        log_reply_t r;
        int         p;
        int         fresh;
        r        = '0;
        r.status = alds_pkg::STATUS_REJECT;
        fresh    = 0;
        if (k == alds_pkg::KIND_APPEND)
        begin
            if (who <= model_limit && int'(who) < ID_SPACE && log_fill < LOG_DEPTH)
            begin
                log_ids[log_fill] = who;
                log_fill++;
                if (visit_tally[who] != alds_pkg::CNT_MAX)
                begin
                    visit_tally[who]++;
                end
                r.status = alds_pkg::STATUS_OK;
                r.visit  = visit_tally[who];
            end
        end
        else if (lo <= hi && int'(hi) < log_fill)
        begin
            for (p = int'(lo); p <= int'(hi); p++)
            begin
                if (!seen_ids[log_ids[p]])
                begin
                    seen_ids[log_ids[p]] = 1'b1;
                    fresh++;
                end
            end
            for (p = int'(lo); p <= int'(hi); p++)
            begin
                seen_ids[log_ids[p]] = 1'b0;
            end
            r.status   = alds_pkg::STATUS_OK;
            r.distinct = alds_pkg::CNT_W'(fresh);
            r.total    = alds_pkg::CNT_W'(int'(hi) - int'(lo) + 1);
        end
        return r;
    endfunction

    function automatic script_row_t row(input logic set_limit,
                                        input logic [alds_pkg::ID_W-1:0] limit,
                                        input logic k,
                                        input logic [alds_pkg::ID_W-1:0] who,
                                        input logic [alds_pkg::POS_W-1:0] lo,
                                        input logic [alds_pkg::POS_W-1:0] hi,
                                        input logic typed, input logic st,
                                        input logic [alds_pkg::CNT_W-1:0] vc,
                                        input logic [alds_pkg::CNT_W-1:0] dc,
                                        input logic [alds_pkg::CNT_W-1:0] tc);
        script_row_t r;
        r.set_limit      = set_limit;
        r.limit          = limit;
        r.kind           = k;
        r.who            = who;
        r.lo             = lo;
        r.hi             = hi;
        r.typed          = typed;
        r.reply.status   = st;
        r.reply.visit    = vc;
        r.reply.distinct = dc;
        r.reply.total    = tc;
        return r;
    endfunction

    // The directed part starts at the reset id limit and an empty log.
    function automatic script_row_t script_row(input int n);
        script_row_t r;
        r = '0;
        case (n)
            0:  r = row(0, 0, alds_pkg::KIND_QUERY, 0, 0, 0, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            1:  r = row(0, 0, alds_pkg::KIND_APPEND, 0, 0, 0, 1,
                        alds_pkg::STATUS_OK, 1, 0, 0);
            2:  r = row(0, 0, alds_pkg::KIND_APPEND, alds_pkg::ID_LIMIT_RESET, 0, 0, 1,
                        alds_pkg::STATUS_OK, 1, 0, 0);
            3:  r = row(0, 0, alds_pkg::KIND_APPEND,
                        alds_pkg::ID_LIMIT_RESET + alds_pkg::ID_W'(1), 0, 0, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            4:  r = row(0, 0, alds_pkg::KIND_APPEND, '1, '1, '1, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            5:  r = row(0, 0, alds_pkg::KIND_APPEND, 0, '1, '1, 1,
                        alds_pkg::STATUS_OK, 2, 0, 0);
            6:  r = row(0, 0, alds_pkg::KIND_APPEND, 5, 0, 0, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            7:  r = row(0, 0, alds_pkg::KIND_APPEND, alds_pkg::ID_LIMIT_RESET, 0, 0, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            8:  r = row(0, 0, alds_pkg::KIND_QUERY, '1, 0, 3, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            9:  r = row(0, 0, alds_pkg::KIND_QUERY, 0, 1, 0, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            10: r = row(0, 0, alds_pkg::KIND_QUERY, 0, 0, 4, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            11: r = row(0, 0, alds_pkg::KIND_QUERY, 0, 0, 5, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            12: r = row(0, 0, alds_pkg::KIND_QUERY, 0, '1, '1, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            13: r = row(0, 0, alds_pkg::KIND_QUERY, 0, '1, 0, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            14: r = row(0, 0, alds_pkg::KIND_QUERY, '1, 3, 3, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            15: r = row(0, 0, alds_pkg::KIND_QUERY, 0, 2, 2, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            16: r = row(1, 0, alds_pkg::KIND_APPEND, 0, 0, 0, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            17: r = row(0, 0, alds_pkg::KIND_APPEND, 1, 0, 0, 1,
                        alds_pkg::STATUS_REJECT, 0, 0, 0);
            18: r = row(1, '1, alds_pkg::KIND_APPEND, '1, 0, 0, 1,
                        alds_pkg::STATUS_OK, 1, 0, 0);
            19: r = row(0, 0, alds_pkg::KIND_APPEND,
                        {alds_pkg::ID_W{1'b1}} - alds_pkg::ID_W'(1), 0, 0, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            20: r = row(0, 0, alds_pkg::KIND_QUERY, 0, 0, 7, 0,
                        alds_pkg::STATUS_OK, 0, 0, 0);
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic send_item(input logic k, input logic [alds_pkg::ID_W-1:0] who,
                             input logic [alds_pkg::POS_W-1:0] lo,
                             input logic [alds_pkg::POS_W-1:0] hi,
                             input int idle_pct, input logic typed, input log_reply_t typed_reply);
        log_reply_t predicted;
        bit         taken;
        taken = 1'b0;
        while (!taken)
        begin
            start       <= ($urandom_range(0, 99) >= idle_pct);
            kind        <= k;
            id          <= who;
            range_start <= lo;
            range_end   <= hi;
            @(posedge clk);
            taken = start && !busy;
        end
        predicted = predict_reply(k, who, lo, hi);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic write_id_limit(input logic [alds_pkg::ID_W-1:0] value);
        start <= 1'b0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        model_limit = value;
    endtask

    // Most traffic is appends of a few recurring ids and short valid queries,
    // so that distinct counts see repeats; the rest is random noise.
    task automatic random_phase(input int items, input int idle_pct);
        logic [alds_pkg::ID_W-1:0]  hot [8];
        logic [alds_pkg::ID_W-1:0]  who;
        logic [alds_pkg::POS_W-1:0] lo;
        logic [alds_pkg::POS_W-1:0] hi;
        log_reply_t                 none;
        int                         n;
        int                         h;
        int                         pick;
        int                         span;
        none   = '0;
        hot[0] = model_limit;
        for (h = 1; h < 8; h++)
        begin
            hot[h] = alds_pkg::ID_W'($urandom_range(0, model_limit));
        end
        for (n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            who  = alds_pkg::ID_W'($urandom);
            lo   = alds_pkg::POS_W'($urandom);
            hi   = alds_pkg::POS_W'($urandom);
            if (pick < 45 || log_fill == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    who = hot[$urandom_range(0, 7)];
                end
                else if (pick < 9)
                begin
                    who = alds_pkg::ID_W'($urandom_range(0, model_limit));
                end
                send_item(alds_pkg::KIND_APPEND, who, lo, hi, idle_pct, 1'b0, none);
            end
            else if (pick < 85)
            begin
                lo   = alds_pkg::POS_W'($urandom_range(0, log_fill - 1));
                span = log_fill - 1 - int'(lo);
                if (span > 48)
                begin
                    span = 48;
                end
                hi = lo + alds_pkg::POS_W'($urandom_range(0, span));
                send_item(alds_pkg::KIND_QUERY, who, lo, hi, idle_pct, 1'b0, none);
            end
            else
            begin
                send_item(alds_pkg::KIND_QUERY, who, lo, hi, idle_pct, 1'b0, none);
            end
        end
    endtask

    task automatic flag_reply(input string what, input log_reply_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s: expected st=%0d vc=%0d dc=%0d tc=%0d, got st=%0d vc=%0d dc=%0d tc=%0d",
                     what, want.status, want.visit, want.distinct, want.total,
                     status, visit_count, distinct_count, total_count);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                flag_reply("unexpected result", '0);
            end
            else
            begin
                check_want = pending_replies.pop_front();
                if (status !== check_want.status || visit_count !== check_want.visit ||
                    distinct_count !== check_want.distinct || total_count !== check_want.total)
                begin
                    flag_reply("result mismatch", check_want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_access_log_distinct_range_counter_unit: errors");
            $finish;
        end
    end

    initial
    begin
        script_row_t r;
        log_reply_t  none;
        int          i;
        none = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (i = 0; i < SCRIPT_ROWS; i++)
        begin
            r = script_row(i);
            if (r.set_limit)
            begin
                write_id_limit(r.limit);
            end
            send_item(r.kind, r.who, r.lo, r.hi, 0, r.typed, r.reply);
        end
        write_id_limit(alds_pkg::ID_W'($urandom));
        random_phase(34, 7);
        write_id_limit(alds_pkg::ID_LIMIT_RESET);
        random_phase(33, 73);
        write_id_limit(alds_pkg::ID_W'($urandom_range(0, 1023)));
        random_phase(33, 0);
        // Close with one query that spans every entry of the log.
        send_item(alds_pkg::KIND_QUERY, alds_pkg::ID_W'($urandom), 0,
                  alds_pkg::POS_W'(log_fill - 1), 0, 1'b0, none);
        start <= 1'b0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
        begin
            $display("tb_access_log_distinct_range_counter_unit: clean");
        end
        else
        begin
            $display("tb_access_log_distinct_range_counter_unit: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/alds_pkg.sv
hdl/alds_ram.sv
hdl/access_log_distinct_range_counter_unit.sv
tb/sv/tb_access_log_distinct_range_counter_unit.sv
